/* hw/rtl/led_blink_code_and_breathe_defines.svh */
// ----------------------------------------------------------------------------
// LED blink code and breathe: assertion macros
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_CODE_AND_BREATHE_DEFINES_SVH
`define LED_BLINK_CODE_AND_BREATHE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LBCB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbcb: implication check failed");

// next-cycle implication
`define LBCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbcb: next-cycle check failed");

`else

`define LBCB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LBCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/lbcb_pkg.sv */
// ----------------------------------------------------------------------------
// lbcb_pkg
// Constants, types and helpers shared by the LED pattern generator.
// ----------------------------------------------------------------------------
package lbcb_pkg;

    // breathe ramp shape
    localparam int LEVEL_COUNT       = 256;
    localparam int BREATHE_PERIOD_MS = 4096;
    localparam int HOLD_RAW          = (BREATHE_PERIOD_MS / 2) / LEVEL_COUNT;
    localparam int HOLD_TICKS        = (HOLD_RAW == 0) ? 1 : HOLD_RAW;
    localparam int LEVEL_W           = $clog2(LEVEL_COUNT);
    localparam int LEVEL_TOP         = LEVEL_COUNT - 1;

    // blink code timing, in ticks
    localparam int LONG_TICKS   = 500;
    localparam int SHORT_TICKS  = 250;
    localparam int GAP_TICKS    = 750;
    localparam int STEADY_TICKS = 1000;
    localparam int SHORT_LIMIT  = 9;

    localparam logic [7:0] FULL_LEVEL = 8'd255;

    localparam int TIMER_MAX = (HOLD_TICKS > STEADY_TICKS) ? HOLD_TICKS : STEADY_TICKS;
    localparam int TIMER_W   = $clog2(TIMER_MAX + 1);

    // register port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [TIMER_W-1:0] t_timer;
    typedef logic [TIMER_W:0]   t_timer_ext;
    typedef logic [LEVEL_W-1:0] t_level;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ERROR   = 2'd1,
        MODE_BREATHE = 2'd2,
        MODE_STEADY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_LONG  = 2'd1,
        REG_SHORT = 2'd2
    } t_reg_idx;

    typedef enum logic [4:0] {
        PH_LONG_ON   = 5'b00001,
        PH_LONG_OFF  = 5'b00010,
        PH_SHORT_ON  = 5'b00100,
        PH_SHORT_OFF = 5'b01000,
        PH_GAP       = 5'b10000
    } t_phase;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] long_blinks;
        logic [3:0] short_blinks;
    } t_cfg;

    typedef struct packed {
        logic   req;
        t_phase first;
    } t_restart;

    // counts above the limit act as the limit
    function automatic logic [3:0] short_count(input logic [3:0] raw);
        return (raw > 4'(SHORT_LIMIT)) ? 4'(SHORT_LIMIT) : raw;
    endfunction

    function automatic t_phase first_phase(input logic [7:0] long_n,
                                           input logic [3:0] short_n);
        t_phase ph;
        if (long_n != 8'd0) begin
            ph = PH_LONG_ON;
        end else if (short_count(short_n) != 4'd0) begin
            ph = PH_SHORT_ON;
        end else begin
            ph = PH_GAP;
        end
        return ph;
    endfunction

    function automatic t_timer_ext phase_len(input t_phase ph);
        t_timer_ext len;
        unique case (ph)
            PH_LONG_ON, PH_LONG_OFF:   len = t_timer_ext'(LONG_TICKS);
            PH_SHORT_ON, PH_SHORT_OFF: len = t_timer_ext'(SHORT_TICKS);
            default:                   len = t_timer_ext'(GAP_TICKS);
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/lbcb_engine.sv */
// ----------------------------------------------------------------------------
// lbcb_engine
// Pattern state: shows the level for the current tick, advances on a step that carries a tick.
// ----------------------------------------------------------------------------
module lbcb_engine
    import lbcb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_restart   i_restart,
    input  logic       i_step,
    input  logic       i_tick,
    output logic [7:0] o_level,
    output logic       o_start
);

    t_phase     r_phase,  n_phase;
    t_timer     r_timer,  n_timer;
    logic [7:0] r_done,   n_done;
    t_level     r_ramp,   n_ramp;
    logic       r_rising, n_rising;

    t_phase     first;
    logic [3:0] short_n;
    t_timer_ext timer_inc;
    logic [8:0] done_inc;

    assign short_n   = short_count(i_cfg.short_blinks);
    assign first     = first_phase(i_cfg.long_blinks, i_cfg.short_blinks);
    assign timer_inc = {1'b0, r_timer} + t_timer_ext'(1);
    assign done_inc  = {1'b0, r_done} + 9'd1;

    // level and cycle mark for the current item
    always_comb begin
        o_level = 8'd0;
        o_start = 1'b0;
        unique case (i_cfg.mode)
            MODE_ERROR: begin
                o_level = (r_phase == PH_LONG_ON || r_phase == PH_SHORT_ON)
                          ? FULL_LEVEL : 8'd0;
                o_start = (r_phase == first) && (r_timer == '0) && (r_done == 8'd0);
            end
            MODE_BREATHE: begin
                o_level = 8'(r_ramp);
                o_start = r_rising && (r_ramp == '0) && (r_timer == '0);
            end
            MODE_STEADY: begin
                o_level = FULL_LEVEL;
                o_start = (r_timer == '0);
            end
            default: begin
                o_level = 8'd0;
                o_start = 1'b0;
            end
        endcase
        o_start = o_start & i_tick;
    end

    // state advance
    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_done   = r_done;
        n_ramp   = r_ramp;
        n_rising = r_rising;
        if (i_restart.req) begin
            n_phase  = i_restart.first;
            n_timer  = '0;
            n_done   = 8'd0;
            n_ramp   = '0;
            n_rising = 1'b1;
        end else if (i_step && i_tick) begin
            unique case (i_cfg.mode)
                MODE_ERROR: begin
                    if (timer_inc < phase_len(r_phase)) begin
                        n_timer = t_timer'(timer_inc);
                    end else begin
                        n_timer = '0;
                        unique case (r_phase)
                            PH_LONG_ON: begin
                                n_phase = PH_LONG_OFF;
                            end
                            PH_LONG_OFF: begin
                                if (done_inc < {1'b0, i_cfg.long_blinks}) begin
                                    n_done  = done_inc[7:0];
                                    n_phase = PH_LONG_ON;
                                end else begin
                                    n_done  = 8'd0;
                                    n_phase = (short_n != 4'd0) ? PH_SHORT_ON : PH_GAP;
                                end
                            end
                            PH_SHORT_ON: begin
                                n_phase = PH_SHORT_OFF;
                            end
                            PH_SHORT_OFF: begin
                                if (done_inc < {5'd0, short_n}) begin
                                    n_done  = done_inc[7:0];
                                    n_phase = PH_SHORT_ON;
                                end else begin
                                    n_done  = 8'd0;
                                    n_phase = PH_GAP;
                                end
                            end
                            default: begin
                                n_done  = 8'd0;
                                n_phase = first;
                            end
                        endcase
                    end
                end
                MODE_BREATHE: begin
                    if (timer_inc < t_timer_ext'(HOLD_TICKS)) begin
                        n_timer = t_timer'(timer_inc);
                    end else begin
                        n_timer = '0;
                        if (r_rising) begin
                            if (r_ramp >= t_level'(LEVEL_TOP)) begin
                                n_rising = 1'b0;
                            end else begin
                                n_ramp = r_ramp + t_level'(1);
                            end
                        end else if (r_ramp <= t_level'(1)) begin
                            n_ramp   = '0;
                            n_rising = 1'b1;
                        end else begin
                            n_ramp = r_ramp - t_level'(1);
                        end
                    end
                end
                MODE_STEADY: begin
                    n_timer = (timer_inc >= t_timer_ext'(STEADY_TICKS))
                              ? '0 : t_timer'(timer_inc);
                end
                default: begin
                    n_timer = r_timer;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_GAP;
            r_timer  <= '0;
            r_done   <= 8'd0;
            r_ramp   <= '0;
            r_rising <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_done   <= n_done;
            r_ramp   <= n_ramp;
            r_rising <= n_rising;
        end
    end

endmodule

/* hw/rtl/led_blink_code_and_breathe.sv */
// ----------------------------------------------------------------------------
// led_blink_code_and_breathe
// Indicator LED pattern generator: blink code, breathe ramp, steady on.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one tick flag (1 = one
// millisecond has passed, 0 = hold) and produces exactly one result: the LED
// level shown for that step and a cycle_start mark. A transaction is taken on
// every clock while the result side keeps up; the result is loaded into the
// output register on acceptance, and a new tick is still taken while that
// result waits, as long as the consumer takes it the same cycle. The pattern
// state updates in the single accept cycle, so the rate is one tick per clock
// while the consumer keeps up, set by the output register. Writing any of the
// three registers (mode at 0x0, long blink count at 0x4, short blink count at
// 0x8) restarts the pattern; writes elsewhere are ignored. Reset leaves the LED
// off (mode 0) with both counts at zero. Short counts above nine act as nine.
// ----------------------------------------------------------------------------
module led_blink_code_and_breathe
    import lbcb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_tick,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_led_level,
    output logic              o_cycle_start,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

`include "led_blink_code_and_breathe_defines.svh"

    // ---------------- configuration registers ----------------
    t_mode      r_mode,  n_mode;
    logic [7:0] r_long,  n_long;
    logic [3:0] r_short, n_short;

    logic       cfg_wr;
    t_reg_idx   cfg_idx;
    t_restart   restart;
    t_cfg       cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    // next register values; restart uses the values being written
    always_comb begin
        n_mode      = r_mode;
        n_long      = r_long;
        n_short     = r_short;
        restart.req = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MODE: begin
                    n_mode      = t_mode'(pwdata[1:0]);
                    restart.req = 1'b1;
                end
                REG_LONG: begin
                    n_long      = pwdata[7:0];
                    restart.req = 1'b1;
                end
                REG_SHORT: begin
                    n_short     = pwdata[3:0];
                    restart.req = 1'b1;
                end
                default: begin
                    restart.req = 1'b0;
                end
            endcase
        end
        restart.first = first_phase(n_long, n_short);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_long  <= 8'd0;
            r_short <= 4'd0;
        end else begin
            r_mode  <= n_mode;
            r_long  <= n_long;
            r_short <= n_short;
        end
    end

    // read back
    always_comb begin
        unique case (cfg_idx)
            REG_MODE:  prdata = DATA_W'(r_mode);
            REG_LONG:  prdata = DATA_W'(r_long);
            REG_SHORT: prdata = DATA_W'(r_short);
            default:   prdata = '0;
        endcase
    end

    assign cfg = '{mode: r_mode, long_blinks: r_long, short_blinks: r_short};

    // ---------------- pattern engine ----------------
    logic       in_acc;
    logic [7:0] eng_level;
    logic       eng_start;

    // output register is free when empty or when its result is taken this cycle
    assign o_ready = !o_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    lbcb_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_step    (in_acc),
        .i_tick    (i_tick),
        .o_level   (eng_level),
        .o_start   (eng_start)
    );

    // ---------------- result register ----------------
    logic       r_out_valid;
    logic [7:0] r_level;
    logic       r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_level <= eng_level;
            r_start <= eng_start;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_led_level   = r_level;
    assign o_cycle_start = r_start;

    // ---------------- checks ----------------
    // a hold step never marks a cycle start
    `LBCB_ASSERT_NEXT(a_hold_no_start, i_clk, i_rst_n, in_acc && !i_tick, o_valid && !o_cycle_start)
    // off mode keeps the LED dark
    `LBCB_ASSERT_NEXT(a_off_dark, i_clk, i_rst_n, in_acc && (r_mode == MODE_OFF), o_led_level == 8'd0)
    // steady mode drives full scale
    `LBCB_ASSERT_NEXT(a_steady_full, i_clk, i_rst_n, in_acc && (r_mode == MODE_STEADY), o_led_level == FULL_LEVEL)
    // cycle mark only on a tick of an active mode
    `LBCB_ASSERT_IMPL(a_start_needs_mode, i_clk, i_rst_n, eng_start, i_tick && (r_mode != MODE_OFF))

endmodule
